/* src/tgcs_pkg.sv */
// Shared types and constants for the text grid cursor and scrollback unit.
// No dependencies; every other file in src imports this package.
package tgcs_pkg;

    localparam logic [13:0] MAX_STORE_ROWS = 14'd16383;
    localparam logic [7:0]  MAX_COLS       = 8'd255;

    localparam logic [7:0]  RST_VISIBLE_ROWS    = 8'd24;
    localparam logic [7:0]  RST_VISIBLE_COLS    = 8'd80;
    localparam logic [13:0] RST_SCROLLBACK_ROWS = 14'd10000;

    localparam logic [1:0] REG_VISIBLE_ROWS    = 2'd0;
    localparam logic [1:0] REG_VISIBLE_COLS    = 2'd1;
    localparam logic [1:0] REG_SCROLLBACK_ROWS = 2'd2;

    localparam logic [7:0] CH_BS    = 8'd8;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_DEL   = 8'd127;

    localparam logic [8:0] TAB_STEP = 9'd8;
    localparam logic [8:0] TAB_MASK = 9'h1F8;

    localparam int NUM_SLOTS = 5;
    localparam int SLOT_CELL       = 0;
    localparam int SLOT_SHIFT      = 1;
    localparam int SLOT_CLR_FULL   = 2;
    localparam int SLOT_CLR_COLORS = 3;
    localparam int SLOT_STATUS     = 4;

    typedef enum logic [2:0] {
        OP_STATUS       = 3'd0,
        OP_WRITE        = 3'd1,
        OP_ERASE        = 3'd2,
        OP_SHIFT        = 3'd3,
        OP_CLEAR_FULL   = 3'd4,
        OP_CLEAR_COLORS = 3'd5
    } op_t;

    typedef struct packed {
        logic        mode;
        logic [7:0]  byte_in;
        logic        render;
        logic [31:0] fg_in;
        logic [31:0] bg_in;
        logic        bold_in;
        logic        italic_in;
        logic        underline_in;
        logic        inverse_in;
        logic [7:0]  wheel_delta;
    } item_t;

    typedef struct packed {
        op_t         op;
        logic [13:0] row;
        logic [7:0]  col;
        logic [7:0]  ch;
        logic [31:0] fg;
        logic [31:0] bg;
        logic        bold;
        logic        italic;
        logic        underline;
        logic [13:0] view_offset;
    } cmd_t;

    typedef struct packed {
        logic [NUM_SLOTS-1:0]       valid;
        cmd_t [NUM_SLOTS-1:0]       cmd;
    } bundle_t;

    // effective configuration after zero and cap rules
    typedef struct packed {
        logic [7:0]  rows;
        logic [7:0]  cols;
        logic [13:0] total;
        logic [13:0] max_off;
    } cfg_t;

endpackage

/* src/tgcs_cfg_regs.sv */
// Configuration registers and effective geometry derivation.
// Depends on tgcs_pkg.
module tgcs_cfg_regs (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [1:0]        cfg_index,
    input  logic [13:0]       cfg_wdata,
    output tgcs_pkg::cfg_t    cfg
);
    import tgcs_pkg::*;

    logic [7:0]  rows_reg;
    logic [7:0]  cols_reg;
    logic [13:0] total_reg;
    logic [7:0]  rows_eff;
    logic [7:0]  cols_nz;
    logic [13:0] total_nz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg  <= RST_VISIBLE_ROWS;
            cols_reg  <= RST_VISIBLE_COLS;
            total_reg <= RST_SCROLLBACK_ROWS;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_VISIBLE_ROWS:    rows_reg  <= cfg_wdata[7:0];
                REG_VISIBLE_COLS:    cols_reg  <= cfg_wdata[7:0];
                REG_SCROLLBACK_ROWS: total_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        rows_eff = (rows_reg == 8'd0) ? 8'd1 : rows_reg;
        cols_nz  = (cols_reg == 8'd0) ? 8'd1 : cols_reg;
        total_nz = (total_reg == 14'd0) ? 14'd1 : total_reg;
        cfg.rows  = rows_eff;
        cfg.cols  = (cols_nz > MAX_COLS) ? MAX_COLS : cols_nz;
        cfg.total = (total_nz > MAX_STORE_ROWS) ? MAX_STORE_ROWS : total_nz;
        cfg.max_off = (cfg.total > {6'd0, rows_eff}) ? (cfg.total - {6'd0, rows_eff})
                                                      : 14'd0;
    end

endmodule

/* src/tgcs_engine.sv */
// Input register, cursor/offset state and the single-pass command builder.
// Depends on tgcs_pkg; hands a full command bundle to tgcs_emitter.
module tgcs_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  tgcs_pkg::cfg_t    cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  tgcs_pkg::item_t   item_in,
    input  logic              bundle_ready,
    output logic              bundle_load,
    output tgcs_pkg::bundle_t bundle
);
    import tgcs_pkg::*;

    item_t       item_reg;
    logic        item_valid_reg;
    logic [7:0]  row_reg, row_next;
    logic [8:0]  col_reg, col_next;
    logic [13:0] off_reg, off_next;

    logic [14:0] arow;
    logic        arow_ok;
    logic [9:0]  col1;
    logic [8:0]  row1;
    logic [8:0]  row2;
    logic [9:0]  col2;
    logic [14:0] off1;
    logic [15:0] ofs_sum;
    logic [13:0] off2;
    logic [15:0] clr;
    logic signed [15:0] d16;
    logic signed [15:0] woff;
    logic [7:0]  c;

    assign bundle_load = item_valid_reg && bundle_ready;
    assign s_ready     = !item_valid_reg || bundle_load;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            row_reg        <= 8'd0;
            col_reg        <= 9'd0;
            off_reg        <= 14'd0;
        end else begin
            if (s_valid && s_ready) begin
                item_valid_reg <= 1'b1;
            end else if (bundle_load) begin
                item_valid_reg <= 1'b0;
            end
            if (bundle_load) begin
                row_reg <= row_next;
                col_reg <= col_next;
                off_reg <= off_next;
            end
        end
    end

    always_comb begin
        bundle   = '0;
        row_next = row_reg;
        col_next = col_reg;
        off_next = off_reg;
        c        = item_reg.byte_in;
        arow     = {1'b0, off_reg} + {7'd0, row_reg};
        arow_ok  = (arow < {1'b0, cfg.total});
        col1     = {1'b0, col_reg};
        row1     = {1'b0, row_reg};
        row2     = 9'd0;
        col2     = 10'd0;
        off1     = 15'd0;
        ofs_sum  = 16'd0;
        off2     = off_reg;
        clr      = 16'd0;
        d16      = {{8{item_reg.wheel_delta[7]}}, item_reg.wheel_delta};
        woff     = $signed({2'b00, off_reg}) - ((d16 <<< 1) + d16);

        if (item_reg.mode) begin
            if (item_reg.wheel_delta != 8'd0) begin
                if (woff[15]) begin
                    off_next = 14'd0;
                end else if (woff[14:0] > {1'b0, cfg.max_off}) begin
                    off_next = cfg.max_off;
                end else begin
                    off_next = woff[13:0];
                end
            end
        end else begin
            if (item_reg.render) begin
                if (c == CH_LF) begin
                    row1 = {1'b0, row_reg} + 9'd1;
                    col1 = 10'd0;
                end else if (c == CH_CR) begin
                    col1 = 10'd0;
                end else if (c == CH_TAB) begin
                    col1 = {1'b0, (col_reg + TAB_STEP) & TAB_MASK};
                end else if (c == CH_BS || c == CH_DEL) begin
                    if (col_reg != 9'd0) begin
                        col1 = {1'b0, col_reg} - 10'd1;
                        if (arow_ok && (col1 < {2'b00, cfg.cols})) begin
                            bundle.valid[SLOT_CELL]       = 1'b1;
                            bundle.cmd[SLOT_CELL].op       = OP_ERASE;
                            bundle.cmd[SLOT_CELL].row      = arow[13:0];
                            bundle.cmd[SLOT_CELL].col      = col1[7:0];
                            bundle.cmd[SLOT_CELL].ch       = CH_SPACE;
                            bundle.cmd[SLOT_CELL].view_offset = off_reg;
                        end
                    end
                end else if (c >= CH_SPACE && c < CH_DEL) begin
                    if (arow_ok && (col_reg < {1'b0, cfg.cols})) begin
                        bundle.valid[SLOT_CELL]        = 1'b1;
                        bundle.cmd[SLOT_CELL].op        = OP_WRITE;
                        bundle.cmd[SLOT_CELL].row       = arow[13:0];
                        bundle.cmd[SLOT_CELL].col       = col_reg[7:0];
                        bundle.cmd[SLOT_CELL].ch        = c;
                        bundle.cmd[SLOT_CELL].fg        = item_reg.inverse_in ? item_reg.bg_in
                                                                              : item_reg.fg_in;
                        bundle.cmd[SLOT_CELL].bg        = item_reg.inverse_in ? item_reg.fg_in
                                                                              : item_reg.bg_in;
                        bundle.cmd[SLOT_CELL].bold      = item_reg.bold_in;
                        bundle.cmd[SLOT_CELL].italic    = item_reg.italic_in;
                        bundle.cmd[SLOT_CELL].underline = item_reg.underline_in;
                        bundle.cmd[SLOT_CELL].view_offset = off_reg;
                    end
                    col1 = {1'b0, col_reg} + 10'd1;
                end
            end

            // line wrap
            if (col1 >= {2'b00, cfg.cols}) begin
                col2 = 10'd0;
                row2 = row1 + 9'd1;
            end else begin
                col2 = col1;
                row2 = row1;
            end

            // scroll
            if (row2 >= {1'b0, cfg.rows}) begin
                off1    = {1'b0, off_reg} + 15'd1;
                ofs_sum = {1'b0, off1} + {8'd0, cfg.rows};
                if (ofs_sum > {2'b00, cfg.total}) begin
                    off2 = cfg.max_off;
                    bundle.valid[SLOT_SHIFT]            = 1'b1;
                    bundle.cmd[SLOT_SHIFT].op            = OP_SHIFT;
                    bundle.cmd[SLOT_SHIFT].view_offset   = off2;
                    bundle.valid[SLOT_CLR_FULL]          = 1'b1;
                    bundle.cmd[SLOT_CLR_FULL].op         = OP_CLEAR_FULL;
                    bundle.cmd[SLOT_CLR_FULL].row        = cfg.total - 14'd1;
                    bundle.cmd[SLOT_CLR_FULL].fg         = item_reg.fg_in;
                    bundle.cmd[SLOT_CLR_FULL].bg         = item_reg.bg_in;
                    bundle.cmd[SLOT_CLR_FULL].view_offset = off2;
                end else begin
                    off2 = off1[13:0];
                end
                clr = {2'b00, off2} + {8'd0, cfg.rows} - 16'd1;
                if (clr < {2'b00, cfg.total}) begin
                    bundle.valid[SLOT_CLR_COLORS]          = 1'b1;
                    bundle.cmd[SLOT_CLR_COLORS].op          = OP_CLEAR_COLORS;
                    bundle.cmd[SLOT_CLR_COLORS].row         = clr[13:0];
                    bundle.cmd[SLOT_CLR_COLORS].fg          = item_reg.fg_in;
                    bundle.cmd[SLOT_CLR_COLORS].bg          = item_reg.bg_in;
                    bundle.cmd[SLOT_CLR_COLORS].view_offset = off2;
                end
                row_next = cfg.rows - 8'd1;
            end else begin
                row_next = row2[7:0];
            end
            col_next = col2[8:0];
            off_next = off2;
        end

        bundle.valid[SLOT_STATUS]            = 1'b1;
        bundle.cmd[SLOT_STATUS].op            = OP_STATUS;
        bundle.cmd[SLOT_STATUS].row           = {6'd0, row_next};
        bundle.cmd[SLOT_STATUS].col           = col_next[7:0];
        bundle.cmd[SLOT_STATUS].view_offset   = off_next;
    end

endmodule

/* src/tgcs_emitter.sv */
// Result bundle register; sends the commands in order, one per m_ready cycle.
// Depends on tgcs_pkg; fed by tgcs_engine.
module tgcs_emitter (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              bundle_load,
    input  tgcs_pkg::bundle_t bundle,
    output logic              bundle_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output tgcs_pkg::cmd_t    m_cmd,
    output logic              m_last
);
    import tgcs_pkg::*;

    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    cmd_t [NUM_SLOTS-1:0] cmd_reg;
    logic [NUM_SLOTS-1:0] first_onehot;

    assign m_valid      = |valid_reg;
    assign m_last       = (valid_reg[SLOT_STATUS-1:0] == '0);
    assign bundle_ready = !m_valid || (m_ready && m_last);

    always_comb begin
        first_onehot = '0;
        m_cmd        = cmd_reg[SLOT_STATUS];
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (valid_reg[i]) begin
                first_onehot = '0;
                first_onehot[i] = 1'b1;
                m_cmd = cmd_reg[i];
            end
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (bundle_load) begin
            valid_next = bundle.valid;
        end else if (m_valid && m_ready) begin
            valid_next = valid_reg & ~first_onehot;
        end
    end

    always_ff @(posedge aclk) begin
        if (bundle_load) begin
            cmd_reg <= bundle.cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

endmodule

/* src/text_grid_cursor_scrollback_unit.sv */
// Top level of the text grid cursor and scrollback unit.
// Depends on tgcs_pkg, tgcs_cfg_regs, tgcs_engine and tgcs_emitter.
//
// Usage:
//   s_ channel: one request per shell byte (s_tuser = 0) or wheel event
//   (s_tuser = 1). m_ channel: the commands for the cell store, op in
//   m_tuser, ending with one status result flagged by m_tlast.
//   cfg_ port: visible rows (0), visible columns (1), scrollback rows (2);
//   write only while the unit is idle. A value of 0 acts as 1.
// Path: input register, then result bundle register, then m_ channel.
// Throughput: one result per cycle while m_tready is high; a request gives
//   1 to 5 commands (status only, up to cell + shift + full clear + color
//   clear + status). The result bundle register and the one-per-cycle
//   emitter set this rate; the input register takes the next request while
//   the current bundle drains.
// Reset: cursor and view offset go to zero, registers to 24 rows, 80
//   columns and 10000 scrollback rows, both channels empty.
// Stall: with m_tready low the pending result holds, one more request waits
//   in the input register, then s_tready drops.
module text_grid_cursor_scrollback_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // byte_in, render, fg_in, bg_in, bold_in, italic_in, underline_in,
    // inverse_in, wheel_delta, zero pad
    input  logic [87:0]  s_tdata,
    // mode
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // row, col, ch, fg, bg, bold, italic, underline, view_offset, zero pad
    output logic [111:0] m_tdata,
    // op
    output logic [2:0]   m_tuser,
    output logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [13:0]  cfg_wdata
);
    import tgcs_pkg::*;

    cfg_t    cfg;
    item_t   item_in;
    bundle_t bundle;
    logic    bundle_load;
    logic    bundle_ready;
    cmd_t    m_cmd;

    always_comb begin
        item_in.mode         = s_tuser;
        item_in.byte_in      = s_tdata[7:0];
        item_in.render       = s_tdata[8];
        item_in.fg_in        = s_tdata[40:9];
        item_in.bg_in        = s_tdata[72:41];
        item_in.bold_in      = s_tdata[73];
        item_in.italic_in    = s_tdata[74];
        item_in.underline_in = s_tdata[75];
        item_in.inverse_in   = s_tdata[76];
        item_in.wheel_delta  = s_tdata[84:77];
    end

    tgcs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tgcs_engine u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .item_in      (item_in),
        .bundle_ready (bundle_ready),
        .bundle_load  (bundle_load),
        .bundle       (bundle)
    );

    tgcs_emitter u_emitter (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .bundle_load  (bundle_load),
        .bundle       (bundle),
        .bundle_ready (bundle_ready),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_cmd        (m_cmd),
        .m_last       (m_tlast)
    );

    assign m_tuser = m_cmd.op;
    assign m_tdata = {1'b0, m_cmd.view_offset, m_cmd.underline, m_cmd.italic,
                      m_cmd.bold, m_cmd.bg, m_cmd.fg, m_cmd.ch, m_cmd.col, m_cmd.row};

endmodule

/* tb/sv/tgcs_cmd_checker.sv */
// Command checker for the text grid cursor and scrollback unit: tracks cursor,
// view offset and geometry, predicts each request's commands and compares them.
// Depends on tgcs_pkg.
module tgcs_cmd_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [87:0]  s_tdata,
    input  logic         s_tuser,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [111:0] m_tdata,
    input  logic [2:0]   m_tuser,
    input  logic         m_tlast,
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [13:0]  cfg_wdata,
    output int           pending,
    output int           mismatches
);
    import tgcs_pkg::*;

    typedef struct packed {
        cmd_t cmd;
        logic last;
    } cmd_entry_t;

    cmd_entry_t  expected_cmds[$];
    int unsigned vis_rows_reg   = 32'(RST_VISIBLE_ROWS);
    int unsigned vis_cols_reg   = 32'(RST_VISIBLE_COLS);
    int unsigned store_rows_reg = 32'(RST_SCROLLBACK_ROWS);
    int unsigned cur_row  = 0;
    int unsigned cur_col  = 0;
    int unsigned view_off = 0;
    int          err_cnt  = 0;

    task automatic push_cmd(input op_t op, input int unsigned row, input int unsigned col,
                            input logic [7:0] ch, input logic [31:0] fg,
                            input logic [31:0] bg, input logic bold, input logic italic,
                            input logic underline, input logic last);
        cmd_entry_t e;
        e.cmd.op          = op;
        e.cmd.row         = row[13:0];
        e.cmd.col         = col[7:0];
        e.cmd.ch          = ch;
        e.cmd.fg          = fg;
        e.cmd.bg          = bg;
        e.cmd.bold        = bold;
        e.cmd.italic      = italic;
        e.cmd.underline   = underline;
        e.cmd.view_offset = view_off[13:0];
        e.last            = last;
        expected_cmds.push_back(e);
    endtask

    task automatic predict_commands(input item_t req);
        int unsigned rows, cols, total, max_off, arow, clr;
        int          off, delta;
        logic [31:0] wr_fg, wr_bg;
        rows  = (vis_rows_reg == 0) ? 1 : vis_rows_reg;
        cols  = (vis_cols_reg == 0) ? 1 : vis_cols_reg;
        if (cols > 32'(MAX_COLS)) cols = 32'(MAX_COLS);
        total = (store_rows_reg == 0) ? 1 : store_rows_reg;
        if (total > 32'(MAX_STORE_ROWS)) total = 32'(MAX_STORE_ROWS);
        max_off = (total > rows) ? total - rows : 0;

        if (req.mode) begin
            delta = int'($signed(req.wheel_delta));
            if (delta != 0) begin
                off = int'(view_off) - 3 * delta;
                if (off < 0) off = 0;
                if (off > int'(max_off)) off = int'(max_off);
                view_off = off;
            end
        end else begin
            if (req.render) begin
                arow = view_off + cur_row;
                case (req.byte_in)
                    CH_LF: begin
                        cur_row++;
                        cur_col = 0;
                    end
                    CH_CR: cur_col = 0;
                    CH_TAB: cur_col = (cur_col + 8) & 'h1F8;
                    CH_BS, CH_DEL: begin
                        if (cur_col > 0) begin
                            cur_col--;
                            if (arow < total && cur_col < cols)
                                push_cmd(OP_ERASE, arow, cur_col, CH_SPACE, 0, 0, 0, 0, 0, 0);
                        end
                    end
                    default: begin
                        if (req.byte_in >= CH_SPACE && req.byte_in < CH_DEL) begin
                            wr_fg = req.inverse_in ? req.bg_in : req.fg_in;
                            wr_bg = req.inverse_in ? req.fg_in : req.bg_in;
                            if (arow < total && cur_col < cols)
                                push_cmd(OP_WRITE, arow, cur_col, req.byte_in, wr_fg, wr_bg,
                                         req.bold_in, req.italic_in, req.underline_in, 0);
                            cur_col++;
                        end
                    end
                endcase
            end

            if (cur_col >= cols) begin
                cur_col = 0;
                cur_row++;
            end

            if (cur_row >= rows) begin
                view_off++;
                if (view_off + rows > total) begin
                    view_off = max_off;
                    push_cmd(OP_SHIFT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
                    push_cmd(OP_CLEAR_FULL, total - 1, 0, 0, req.fg_in, req.bg_in, 0, 0, 0, 0);
                end
                clr = view_off + rows - 1;
                if (clr < total)
                    push_cmd(OP_CLEAR_COLORS, clr, 0, 0, req.fg_in, req.bg_in, 0, 0, 0, 0);
                cur_row = rows - 1;
            end
            cur_row &= 'hFF;
            cur_col &= 'h1FF;
        end

        push_cmd(OP_STATUS, cur_row, cur_col, 0, 0, 0, 0, 0, 0, 1);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        item_t      req;
        cmd_entry_t want;
        if (!aresetn) begin
            vis_rows_reg   = 32'(RST_VISIBLE_ROWS);
            vis_cols_reg   = 32'(RST_VISIBLE_COLS);
            store_rows_reg = 32'(RST_SCROLLBACK_ROWS);
            cur_row  = 0;
            cur_col  = 0;
            view_off = 0;
            expected_cmds.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_VISIBLE_ROWS:    vis_rows_reg   = 32'(cfg_wdata[7:0]);
                    REG_VISIBLE_COLS:    vis_cols_reg   = 32'(cfg_wdata[7:0]);
                    REG_SCROLLBACK_ROWS: store_rows_reg = 32'(cfg_wdata[13:0]);
                    default: ;
                endcase
            end

            if (s_tvalid && s_tready) begin
                req.mode         = s_tuser;
                req.byte_in      = s_tdata[7:0];
                req.render       = s_tdata[8];
                req.fg_in        = s_tdata[40:9];
                req.bg_in        = s_tdata[72:41];
                req.bold_in      = s_tdata[73];
                req.italic_in    = s_tdata[74];
                req.underline_in = s_tdata[75];
                req.inverse_in   = s_tdata[76];
                req.wheel_delta  = s_tdata[84:77];
                predict_commands(req);
            end

            if (m_tvalid && m_tready) begin
                if (expected_cmds.size() == 0) begin
                    $error("op %0d command arrived with nothing expected", m_tuser);
                    err_cnt++;
                end else begin
                    want = expected_cmds.pop_front();
                    check_field("op", 32'(want.cmd.op), 32'(m_tuser));
                    check_field("row", 32'(want.cmd.row), 32'(m_tdata[13:0]));
                    check_field("col", 32'(want.cmd.col), 32'(m_tdata[21:14]));
                    check_field("ch", 32'(want.cmd.ch), 32'(m_tdata[29:22]));
                    check_field("fg", want.cmd.fg, m_tdata[61:30]);
                    check_field("bg", want.cmd.bg, m_tdata[93:62]);
                    check_field("bold", 32'(want.cmd.bold), 32'(m_tdata[94]));
                    check_field("italic", 32'(want.cmd.italic), 32'(m_tdata[95]));
                    check_field("underline", 32'(want.cmd.underline), 32'(m_tdata[96]));
                    check_field("view_offset", 32'(want.cmd.view_offset),
                                32'(m_tdata[110:97]));
                    check_field("last", 32'(want.last), 32'(m_tlast));
                end
            end
        end
        pending    <= expected_cmds.size();
        mismatches <= err_cnt;
    end

endmodule

/* tb/sv/text_grid_cursor_scrollback_unit_tb.sv */
// Testbench top for the text grid cursor and scrollback unit: drives shell bytes,
// wheel events and geometry writes under varying back-pressure, reports the verdict.
// Depends on tgcs_pkg, tgcs_cmd_checker and text_grid_cursor_scrollback_unit.
module text_grid_cursor_scrollback_unit_tb;
    import tgcs_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [87:0]  s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [111:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [13:0]  cfg_wdata = '0;

    int pending;
    int mismatches;
    int cycles         = 0;
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int hold_len       = 0;

    text_grid_cursor_scrollback_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    tgcs_cmd_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .pending    (pending),
        .mismatches (mismatches)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off when requested
    initial begin : receiver
        int hold_cnt;
        hold_cnt = 0;
        forever begin
            @(posedge aclk);
            if (hold_len > 0) begin
                hold_cnt = hold_len;
                hold_len = 0;
            end
            if (hold_cnt > 0) begin
                m_tready <= 1'b0;
                hold_cnt--;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    function automatic item_t rand_item();
        item_t it;
        it.mode         = 1'b0;
        it.byte_in      = 8'($urandom_range(255));
        it.render       = 1'($urandom_range(1));
        it.fg_in        = $urandom();
        it.bg_in        = $urandom();
        it.bold_in      = 1'($urandom_range(1));
        it.italic_in    = 1'($urandom_range(1));
        it.underline_in = 1'($urandom_range(1));
        it.inverse_in   = 1'($urandom_range(1));
        it.wheel_delta  = 8'($urandom_range(255));
        return it;
    endfunction

    task automatic send_req(input item_t it);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.mode;
        s_tdata  <= {3'b000, it.wheel_delta, it.inverse_in, it.underline_in, it.italic_in,
                     it.bold_in, it.bg_in, it.fg_in, it.render, it.byte_in};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic shell_byte(input logic [7:0] b, input logic render);
        item_t it;
        it         = rand_item();
        it.byte_in = b;
        it.render  = render;
        send_req(it);
    endtask

    task automatic wheel_tick(input logic [7:0] delta);
        item_t it;
        it             = rand_item();
        it.mode        = 1'b1;
        it.wheel_delta = delta;
        send_req(it);
    endtask

    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(99);
        if (r < 55)      return 8'($urandom_range(126, 32));
        else if (r < 67) return CH_LF;
        else if (r < 73) return CH_CR;
        else if (r < 79) return CH_TAB;
        else if (r < 85) return $urandom_range(1) ? CH_BS : CH_DEL;
        else if (r < 92) return 8'($urandom_range(31));
        else             return 8'($urandom_range(255, 128));
    endfunction

    task automatic random_req();
        logic [7:0] d;
        if ($urandom_range(99) < 12) begin
            if ($urandom_range(3) == 0) d = 8'($urandom_range(255));
            else d = 8'($urandom_range(6) - 3);
            wheel_tick(d);
        end else begin
            shell_byte(pick_byte(), $urandom_range(99) < 88);
        end
    endtask

    task automatic set_geometry(input int rows, input int cols, input int total);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_VISIBLE_ROWS;
        cfg_wdata <= 14'(rows);
        @(posedge aclk);
        cfg_index <= REG_VISIBLE_COLS;
        cfg_wdata <= 14'(cols);
        @(posedge aclk);
        cfg_index <= REG_SCROLLBACK_ROWS;
        cfg_wdata <= 14'(total);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (6) @(posedge aclk);
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // small screen so scrolling and the store shift come quickly
        set_geometry(3, 10, 5);
        shell_byte(CH_SPACE, 1);
        shell_byte(8'd126, 1);
        shell_byte("A", 0);
        shell_byte(CH_TAB, 1);
        shell_byte(CH_CR, 1);
        shell_byte(CH_BS, 1);
        shell_byte("B", 1);
        shell_byte(CH_DEL, 1);
        shell_byte(8'd0, 1);
        shell_byte(8'd31, 1);
        shell_byte(8'd128, 1);
        shell_byte(8'd255, 1);
        repeat (4) shell_byte(CH_LF, 1);
        wheel_tick(8'd127);
        wheel_tick(8'h80);
        wheel_tick(8'd0);
        wheel_tick(8'd1);
        wheel_tick(8'hFF);
        shell_byte(CH_TAB, 1);
        shell_byte("x", 1);
        shell_byte("y", 1);
        wait_idle();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    src_idle_pct = 0;  sink_stall_pct = 0;
                    set_geometry(4, 8, 12);
                end
                1: begin
                    src_idle_pct = 61; sink_stall_pct = 0;
                    set_geometry(0, 0, 0);
                end
                2: begin
                    src_idle_pct = 0;  sink_stall_pct = 61;
                    set_geometry(255, 255, 16383);
                end
                default: begin
                    src_idle_pct = 31; sink_stall_pct = 31;
                    set_geometry(10, 3, 4);
                    // cursor left past the new row width
                    shell_byte("x", 1);
                    shell_byte(CH_BS, 1);
                end
            endcase
            repeat (18) random_req();
            if (p == 0) begin
                hold_len = 60;
                repeat (10) random_req();
            end
            if (p == 2) repeat (6) shell_byte(CH_TAB, 1);
            wait_idle();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
